// File: sv/xkb_pkg.sv
// package for the xor distance k-bucket table
// holds widths, status and function codes and the controller/datapath structs
package xkb_pkg;
    localparam int ID_BITS     = 64;
    localparam int INFO_BITS   = 32;
    localparam int BUCKET_SIZE = 8;
    localparam int BKT_W       = (ID_BITS > 1) ? $clog2(ID_BITS) : 1;
    localparam int SLOT_W      = (BUCKET_SIZE > 1) ? $clog2(BUCKET_SIZE) : 1;
    localparam int CNT_W       = $clog2(BUCKET_SIZE + 1);
    localparam int ROW_W       = BUCKET_SIZE * (ID_BITS + INFO_BITS);

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_EVICT  = 2'd2;

    localparam logic [2:0] ST_ADDED    = 3'd0;
    localparam logic [2:0] ST_UPDATED  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_OWN      = 3'd3;
    localparam logic [2:0] ST_REMOVED  = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_REPLACED = 3'd6;
    localparam logic [2:0] ST_EMPTY    = 3'd7;

    typedef struct packed {
        logic load;   // capture request, start row read
        logic modify; // row data is back, compute and write
        logic finish; // load result register
    } xkb_cmd_t;

    typedef struct packed {
        logic own_id;
    } xkb_stat_t;
endpackage

// File: sv/xkb_ctrl.sv
// controller for the k-bucket table
// sequences load, row read, modify/write and result; uses xkb_pkg
module xkb_ctrl import xkb_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  xkb_stat_t stat,
    output xkb_cmd_t  cmd
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_MOD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    // a pending result may sit while a new request starts
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: state_next = stat.own_id ? S_OUT : S_MOD;
            S_MOD: begin
                cmd.modify = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    cmd.finish  = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

// File: sv/xkb_datapath.sv
// datapath of the k-bucket table: row memory, counts, compare and shift
// uses xkb_pkg; driven by xkb_ctrl commands
module xkb_datapath import xkb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [ID_BITS-1:0]   self_id,
    input  logic [1:0]           in_func,
    input  logic [ID_BITS-1:0]   in_id,
    input  logic [INFO_BITS-1:0] in_info,
    input  xkb_cmd_t             cmd,
    output xkb_stat_t            stat,
    output logic [2:0]           out_status,
    output logic [5:0]           out_bucket,
    output logic [3:0]           out_fill,
    output logic                 out_head_valid,
    output logic [63:0]          out_head_id,
    output logic [31:0]          out_head_info
);
    localparam int EW = ID_BITS + INFO_BITS;

    logic [ROW_W-1:0] mem [ID_BITS];
    logic [ROW_W-1:0] row_reg;
    logic [CNT_W-1:0] cnt_reg [ID_BITS];
    logic [CNT_W-1:0] cnt_rd_reg;
    logic [1:0]           func_reg;
    logic [ID_BITS-1:0]   id_reg;
    logic [INFO_BITS-1:0] info_reg;
    logic [BKT_W-1:0]     bkt_reg;
    logic                 own_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [2:0]           st_reg;
    logic [ROW_W-1:0]     nrow_reg;

    // bucket index from highest set bit
    logic [ID_BITS-1:0] xor_dist;
    logic [BKT_W-1:0]   bkt;
    always_comb begin
        xor_dist = self_id ^ in_id;
        bkt      = '0;
        for (int i = 1; i < ID_BITS; i++)
            if (xor_dist[i]) bkt = BKT_W'(i);
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg   <= in_func;
            id_reg     <= in_id;
            info_reg   <= in_info;
            bkt_reg    <= bkt;
            own_reg    <= (xor_dist == '0);
            row_reg    <= mem[bkt];
            cnt_rd_reg <= cnt_reg[bkt];
        end
    end
    assign stat.own_id = own_reg;

    // compute new row
    logic [CNT_W-1:0] n;
    logic [EW-1:0]    ent [BUCKET_SIZE];
    logic [EW-1:0]    res [BUCKET_SIZE];
    logic [BUCKET_SIZE-1:0] hit;
    logic [CNT_W-1:0] nn;
    logic [2:0]       st;
    logic             found;
    logic [SLOT_W-1:0] fpos;
    logic [CNT_W-1:0] j;
    logic [ROW_W-1:0] nrow;
    always_comb begin
        n = (cnt_rd_reg > CNT_W'(BUCKET_SIZE)) ? CNT_W'(BUCKET_SIZE) : cnt_rd_reg;
        found = 1'b0;
        fpos  = '0;
        for (int i = 0; i < BUCKET_SIZE; i++) begin
            ent[i] = row_reg[i*EW +: EW];
            res[i] = ent[i];
            hit[i] = (CNT_W'(i) < n) && (ent[i][ID_BITS-1:0] == id_reg);
        end
        for (int i = BUCKET_SIZE-1; i >= 0; i--)
            if (hit[i]) begin
                found = 1'b1;
                fpos  = SLOT_W'(i);
            end
        nn = n;
        j  = '0;
        case (func_reg)
            FUNC_ADD: begin
                if (found) begin
                    for (int i = 0; i < BUCKET_SIZE; i++)
                        if (SLOT_W'(i) >= fpos && CNT_W'(i + 1) < n)
                            res[i] = ent[(i + 1) % BUCKET_SIZE];
                    for (int i = 0; i < BUCKET_SIZE; i++)
                        if (CNT_W'(i + 1) == n) res[i] = {info_reg, id_reg};
                    st = ST_UPDATED;
                end else if (n < CNT_W'(BUCKET_SIZE)) begin
                    for (int i = 0; i < BUCKET_SIZE; i++)
                        if (CNT_W'(i) == n) res[i] = {info_reg, id_reg};
                    nn = n + 1'b1;
                    st = ST_ADDED;
                end else begin
                    st = ST_FULL;
                end
            end
            FUNC_REMOVE: begin
                // compaction: target index is the count of kept entries before
                for (int i = 0; i < BUCKET_SIZE; i++) begin
                    if ((CNT_W'(i) < n) && !hit[i]) begin
                        for (int k = 0; k < BUCKET_SIZE; k++)
                            if (CNT_W'(k) == j) res[k] = ent[i];
                        j = j + 1'b1;
                    end
                end
                st = (j < n) ? ST_REMOVED : ST_NOTFOUND;
                nn = j;
            end
            FUNC_EVICT: begin
                if (n == '0) begin
                    st = ST_EMPTY;
                end else begin
                    for (int i = 0; i < BUCKET_SIZE - 1; i++)
                        if (CNT_W'(i + 1) < n) res[i] = ent[i + 1];
                    for (int i = 0; i < BUCKET_SIZE; i++)
                        if (CNT_W'(i + 1) == n) res[i] = {info_reg, id_reg};
                    st = ST_REPLACED;
                end
            end
            default: st = ST_NOTFOUND;
        endcase
        for (int i = 0; i < BUCKET_SIZE; i++)
            nrow[i*EW +: EW] = res[i];
    end

    always_ff @(posedge aclk) begin
        if (cmd.modify) begin
            mem[bkt_reg] <= nrow;
            nrow_reg     <= nrow;
            n_reg        <= nn;
            st_reg       <= st;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < ID_BITS; i++) cnt_reg[i] <= '0;
        end else if (cmd.modify) begin
            cnt_reg[bkt_reg] <= nn;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            if (own_reg) begin
                out_status     <= ST_OWN;
                out_bucket     <= '0;
                out_fill       <= '0;
                out_head_valid <= 1'b0;
                out_head_id    <= '0;
                out_head_info  <= '0;
            end else begin
                out_status     <= st_reg;
                out_bucket     <= 6'(bkt_reg);
                out_fill       <= 4'(n_reg);
                out_head_valid <= (n_reg != '0);
                out_head_id    <= (n_reg != '0) ? 64'(nrow_reg[ID_BITS-1:0]) : '0;
                out_head_info  <= (n_reg != '0) ? 32'(nrow_reg[ID_BITS +: INFO_BITS]) : '0;
            end
        end
    end
endmodule

// File: sv/xor_distance_kbucket_table_unit.sv
// top level of the xor distance k-bucket routing table
// joins xkb_ctrl and xkb_datapath; holds the apb register; uses xkb_pkg
//
// each request steps through capture with bucket row and count read,
// row data registered, compare/shift/write-back of the whole row, result
// register load. a request for the block's own id skips the write-back.
// the row memory is read once per request and written at most once, in
// the write-back step. while a result waits on m_tready the next
// request is still accepted and runs up to its result load, where it waits
// until the result slot frees. no clearing pass: bucket counts reset in
// flip-flops, slots are read only below count.
// own id requests return status own id with all other fields zero.
module xor_distance_kbucket_table_unit import xkb_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: node_id[63:0], node_info[95:64]
    input  logic [95:0]  s_tdata,
    // tuser: func[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: status[2:0], bucket_index[8:3], bucket_fill[12:9],
    // head_valid[13], head_id[77:14], head_info[109:78], zero fill to 111
    output logic [111:0] m_tdata
);
    logic [63:0] self_id_reg;
    xkb_cmd_t    cmd;
    xkb_stat_t   stat;
    logic [2:0]  o_st;
    logic [5:0]  o_b;
    logic [3:0]  o_f;
    logic        o_hv;
    logic [63:0] o_hid;
    logic [31:0] o_hinfo;

    // single register at address zero
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? self_id_reg : '0;
    always_ff @(posedge aclk) begin
        if (!aresetn) self_id_reg <= '0;
        else if (psel && penable && pwrite && paddr == 3'd0) self_id_reg <= pwdata;
    end

    xkb_ctrl u_ctrl (
        .aclk, .aresetn, .s_tvalid, .s_tready, .m_tvalid, .m_tready,
        .stat, .cmd
    );

    xkb_datapath u_dp (
        .aclk, .aresetn,
        .self_id  (self_id_reg[ID_BITS-1:0]),
        .in_func  (s_tuser),
        .in_id    (s_tdata[ID_BITS-1:0]),
        .in_info  (s_tdata[64 +: INFO_BITS]),
        .cmd, .stat,
        .out_status (o_st), .out_bucket (o_b), .out_fill (o_f),
        .out_head_valid (o_hv), .out_head_id (o_hid), .out_head_info (o_hinfo)
    );

    assign m_tdata = {2'b00, o_hinfo, o_hid, o_hv, o_f, o_b, o_st};
endmodule
